// ===== design/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg
// shared constants, types and curve arithmetic for the bezier easing block
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int FIELD_W = 17;
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_BISECT_STEPS = 15;
  localparam int WORK_BITS = 30;
  localparam int WORK_W = 31;      // q30 value up to 1.0 inclusive
  localparam int MUL_W = 2 * WORK_W;

  typedef logic [WORK_W-1:0] work_t;

  // input transaction as seen on the channel
  typedef struct packed {
    logic [FIELD_W-1:0] ctrl_x1;
    logic [FIELD_W-1:0] ctrl_y1;
    logic [FIELD_W-1:0] ctrl_x2;
    logic [FIELD_W-1:0] ctrl_y2;
    logic [FIELD_W-1:0] progress;
  } req_t;

  // per-item payload carried along the pipeline
  typedef struct packed {
    work_t x1;
    work_t y1;
    work_t x2;
    work_t y2;
    work_t p;
  } ctrl_t;

  function automatic work_t qmul(input work_t a, input work_t b);
    logic [MUL_W-1:0] prod;
    prod = {{WORK_W{1'b0}}, a} * {{WORK_W{1'b0}}, b};
    return prod[WORK_BITS +: WORK_W];
  endfunction

  function automatic work_t times3(input work_t a);
    logic [WORK_W+1:0] sum;
    sum = {2'b00, a} + {1'b0, a, 1'b0};
    return sum[WORK_W-1:0];
  endfunction

endpackage

// ===== design/cbe_if.sv =====
// ----------------------------------------------------------------------------
// cbe_if
// valid/ready channel carrying a packed payload
// ----------------------------------------------------------------------------
interface cbe_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/cubic_bezier_easing.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_easing
// cubic bezier easing curve solved by fixed-step bisection, fully pipelined
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle while the output is not stalled and returns
// one eased value per input in order. Every bisection step and the final y
// evaluation own an entry register followed by a four-stage curve unit, and the
// result is registered once more at the output; a stalled output freezes the
// whole pipeline, which holds every item.
module cubic_bezier_easing #(
  parameter int FRAC_BITS = cbe_pkg::DEF_FRAC_BITS,
  parameter int BISECT_STEPS = cbe_pkg::DEF_BISECT_STEPS
) (
  input logic clk,
  input logic rst,
  cbe_if.sink   in_ch,
  cbe_if.source out_ch
);
  import cbe_pkg::*;

  localparam int TBITS = BISECT_STEPS + 1;
  localparam int LAT = 4;
  localparam int NU = BISECT_STEPS + 1;
  // 1.0 only fits the field when the fraction is narrower than the field
  localparam bit IN_CLAMP = FRAC_BITS < FIELD_W;
  localparam logic [FIELD_W-1:0] ONE_IN = FIELD_W'(1) << FRAC_BITS;

  function automatic work_t take(input logic [FIELD_W-1:0] raw);
    logic [FIELD_W-1:0] v;
    work_t w;
    v = (IN_CLAMP && raw > ONE_IN) ? ONE_IN : raw;
    if (FRAC_BITS <= WORK_BITS) w = WORK_W'(v) << (WORK_BITS - FRAC_BITS);
    else w = WORK_W'(v >> (FRAC_BITS - WORK_BITS));
    return w;
  endfunction

  function automatic work_t t_work(input logic [TBITS:0] m);
    work_t w;
    if (TBITS <= WORK_BITS) w = WORK_W'(m) << (WORK_BITS - TBITS);
    else w = WORK_W'(m >> (TBITS - WORK_BITS));
    return w;
  endfunction

  logic en;
  logic out_valid;
  logic [FIELD_W-1:0] out_data;
  assign en = !out_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  // per unit: entry registers hold item, bounds; delay lines match curve latency
  ctrl_t          u_ctl [NU][LAT+1];
  logic [TBITS:0] u_lo  [NU][LAT+1];
  logic [TBITS:0] u_hi  [NU][LAT+1];
  logic           u_vld [NU][LAT+1];
  work_t          u_res [NU];

  for (genvar u = 0; u < NU; u++) begin : g_unit
    logic [TBITS:0] mid;
    assign mid = (u_lo[u][0] + u_hi[u][0]) >> 1;

    cbe_curve i_curve (
      .clk (clk),
      .en  (en),
      .t   (t_work(mid)),
      .c1  ((u == NU-1) ? u_ctl[u][0].y1 : u_ctl[u][0].x1),
      .c2  ((u == NU-1) ? u_ctl[u][0].y2 : u_ctl[u][0].x2),
      .res (u_res[u])
    );

    for (genvar k = 1; k <= LAT; k++) begin : g_dly
      always_ff @(posedge clk) begin
        if (rst) begin
          u_vld[u][k] <= 1'b0;
        end else if (en) begin
          u_vld[u][k] <= u_vld[u][k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          u_ctl[u][k] <= u_ctl[u][k-1];
          u_lo[u][k]  <= (k == 1) ? mid : u_lo[u][k-1];
          u_hi[u][k]  <= u_hi[u][k-1];
        end
      end
    end

    if (u == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          u_vld[0][0] <= 1'b0;
        end else if (en) begin
          u_vld[0][0] <= in_ch.valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          u_ctl[0][0] <= '{x1: take(in_ch.data.ctrl_x1), y1: take(in_ch.data.ctrl_y1),
                           x2: take(in_ch.data.ctrl_x2), y2: take(in_ch.data.ctrl_y2),
                           p: take(in_ch.data.progress)};
          u_lo[0][0] <= '0;
          u_hi[0][0] <= (TBITS+1)'(1) << TBITS;
        end
      end
    end else begin : g_next
      // lo tap of the previous unit holds its midpoint, so the original lo is
      // recovered as 2*mid - hi (midpoints are exact)
      logic [TBITS:0] lo_back;
      assign lo_back = {u_lo[u-1][LAT][TBITS-1:0], 1'b0} - u_hi[u-1][LAT];

      always_ff @(posedge clk) begin
        if (rst) begin
          u_vld[u][0] <= 1'b0;
        end else if (en) begin
          u_vld[u][0] <= u_vld[u-1][LAT];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          u_ctl[u][0] <= u_ctl[u-1][LAT];
          if (u_res[u-1] < u_ctl[u-1][LAT].p) begin
            u_lo[u][0] <= u_lo[u-1][LAT];
            u_hi[u][0] <= u_hi[u-1][LAT];
          end else begin
            u_lo[u][0] <= lo_back;
            u_hi[u][0] <= u_lo[u-1][LAT];
          end
        end
      end
    end
  end

  work_t y_q;
  assign y_q = u_res[NU-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= u_vld[NU-1][LAT];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (FRAC_BITS <= WORK_BITS) out_data <= FIELD_W'(y_q >> (WORK_BITS - FRAC_BITS));
      else out_data <= FIELD_W'(y_q) << (FRAC_BITS - WORK_BITS);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_data))
    else $error("result lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("pipeline blocked with empty output");
  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && IN_CLAMP |-> out_data <= ONE_IN)
    else $error("eased value above one");
endmodule

// ===== design/cbe_curve.sv =====
// ----------------------------------------------------------------------------
// cbe_curve
// pipelined evaluation of one bezier coordinate at parameter t, four stages
// ----------------------------------------------------------------------------
module cbe_curve (
  input  logic          clk,
  input  logic          en,
  input  cbe_pkg::work_t t,
  input  cbe_pkg::work_t c1,
  input  cbe_pkg::work_t c2,
  output cbe_pkg::work_t res
);
  import cbe_pkg::*;

  localparam work_t WORK_ONE = work_t'(1) << WORK_BITS;

  // stage a: s, t2, s2
  work_t a_t, a_s, a_t2, a_s2, a_c1, a_c2;
  // stage b: t3, 3*s2t, 3*st2
  work_t b_t3, b_w1, b_w2, b_c1, b_c2;
  // stage c: weighted terms
  work_t c_t1, c_t2, c_t3;

  always_ff @(posedge clk) begin
    if (en) begin
      a_t  <= t;
      a_s  <= WORK_ONE - t;
      a_t2 <= qmul(t, t);
      a_s2 <= qmul(WORK_ONE - t, WORK_ONE - t);
      a_c1 <= c1;
      a_c2 <= c2;
      b_t3 <= qmul(a_t2, a_t);
      b_w1 <= times3(qmul(a_s2, a_t));
      b_w2 <= times3(qmul(a_s, a_t2));
      b_c1 <= a_c1;
      b_c2 <= a_c2;
      c_t1 <= qmul(b_w1, b_c1);
      c_t2 <= qmul(b_w2, b_c2);
      c_t3 <= b_t3;
      res  <= c_t1 + c_t2 + c_t3;
    end
  end
endmodule
